// ===== src/nearest_k_insertion_ranking_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms. Each one is clocked on clk and is
// disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef NEAREST_K_INSERTION_RANKING_MACROS_SVH
`define NEAREST_K_INSERTION_RANKING_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define NKR_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define NKR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/nkr_pkg.sv =====
// ----------------------------------------------------------------------------
// nkr_pkg
// Types and constants shared by the ranking list cells and the top level.
// ----------------------------------------------------------------------------
package nkr_pkg;

    localparam int HANDLE_W = 8;
    localparam int DIST_W   = 32;
    localparam int RANK_W   = 6;
    localparam int CMD_W    = 2;

    // Command codes carried on the request channel.
    typedef enum logic [CMD_W-1:0] {
        CMD_CLEAR  = 2'd0,
        CMD_INSERT = 2'd1,
        CMD_QUERY  = 2'd2
    } cmd_e;

    // Contents of one slot of the list.
    typedef struct packed {
        logic [HANDLE_W-1:0] handle;
        logic                present;
        logic [DIST_W-1:0]   distance;
    } slot_t;

    // Broadcast from the top level to every cell for one accepted transaction.
    typedef struct packed {
        logic                clear;
        logic                insert;
        logic [HANDLE_W-1:0] handle;
        logic [DIST_W-1:0]   distance;
    } cell_ctrl_t;

endpackage

// ===== src/nkr_req_if.sv =====
// ----------------------------------------------------------------------------
// nkr_req_if
// Request channel: command, item to insert and rank to read.
// ----------------------------------------------------------------------------
interface nkr_req_if;
    import nkr_pkg::*;

    logic                valid;
    logic                ready;
    logic [CMD_W-1:0]    cmd;
    logic [HANDLE_W-1:0] item_handle;
    logic [DIST_W-1:0]   item_distance;
    logic [RANK_W-1:0]   query_rank;

    modport source (
        output valid,
        input  ready,
        output cmd,
        output item_handle,
        output item_distance,
        output query_rank
    );

    modport sink (
        input  valid,
        output ready,
        input  cmd,
        input  item_handle,
        input  item_distance,
        input  query_rank
    );
endinterface

// ===== src/nkr_rsp_if.sv =====
// ----------------------------------------------------------------------------
// nkr_rsp_if
// Response channel: contents of the queried rank.
// ----------------------------------------------------------------------------
interface nkr_rsp_if;
    import nkr_pkg::*;

    logic                valid;
    logic                ready;
    logic [HANDLE_W-1:0] ranked_handle;
    logic                ranked_present;
    logic [DIST_W-1:0]   ranked_distance;

    modport source (
        output valid,
        input  ready,
        output ranked_handle,
        output ranked_present,
        output ranked_distance
    );

    modport sink (
        input  valid,
        output ready,
        input  ranked_handle,
        input  ranked_present,
        input  ranked_distance
    );
endinterface

// ===== src/nearest_k_insertion_ranking.sv =====
// ----------------------------------------------------------------------------
// nearest_k_insertion_ranking
// Sorted list of the DEPTH nearest items, built as a chain of slot cells.
//
//   Channel  Dir  Transaction
//   req      in   cmd, item_handle, item_distance, query_rank
//   rsp      out  ranked_handle, ranked_present, ranked_distance (query only)
//
// Each transaction is handled by all cells at once: they compare in parallel and the found
// flag ripples down the chain, so an insert or clear lands in the next cycle.
// A query result is registered and appears on rsp the cycle after acceptance.
// req is stalled only while a query result waits on rsp and rsp is not ready.
// Reset empties every slot and drops any pending result.
// ----------------------------------------------------------------------------
`include "nearest_k_insertion_ranking_macros.svh"

module nearest_k_insertion_ranking #(
    parameter int DEPTH = 8
) (
    input  logic       clk,
    input  logic       rst_n,
    nkr_req_if.sink    req,
    nkr_rsp_if.source  rsp
);
    import nkr_pkg::*;

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic        req_fire;
    cell_ctrl_t  ctrl;
    slot_t       slots     [DEPTH];
    logic        found     [DEPTH+1];
    slot_t       chain_in  [DEPTH];
    logic [DEPTH-1:0] present_vec;

    logic        rank_ok;
    logic [IDX_W-1:0] rank_idx;
    slot_t       rsp_slot_reg;
    slot_t       rsp_slot_next;
    logic        rsp_valid_reg;
    logic        rsp_valid_next;
    logic        is_query;

    // Request handshake and command decode.
    assign req.ready = !rsp_valid_reg || rsp.ready;
    assign req_fire  = req.valid && req.ready;

    always_comb
    begin
        ctrl          = '0;
        is_query      = 1'b0;
        ctrl.handle   = req.item_handle;
        ctrl.distance = req.item_distance;
        unique case (req.cmd)
            CMD_CLEAR:  ctrl.clear  = req_fire;
            CMD_INSERT: ctrl.insert = req_fire;
            CMD_QUERY:  is_query    = req_fire;
            default:    ;
        endcase
    end

    // Chain of slot cells.
    assign found[0] = 1'b0;

    for (genvar k = 0; k < DEPTH; k++)
    begin : g_cell
        if (k == 0)
        begin : g_head
            assign chain_in[k] = '0;
        end
        else
        begin : g_link
            assign chain_in[k] = slots[k-1];
        end

        nkr_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctrl       (ctrl),
            .prev_slot  (chain_in[k]),
            .prev_found (found[k]),
            .slot       (slots[k]),
            .found      (found[k+1])
        );

        assign present_vec[k] = slots[k].present;
    end

    // Query read: ranks beyond the list read as an empty slot.
    assign rank_ok  = ({1'b0, req.query_rank} < (RANK_W+1)'(DEPTH));
    assign rank_idx = req.query_rank[IDX_W-1:0];

    always_comb
    begin
        rsp_slot_next  = rsp_slot_reg;
        rsp_valid_next = rsp_valid_reg && !rsp.ready;
        if (is_query)
        begin
            rsp_valid_next = 1'b1;
            rsp_slot_next  = rank_ok ? slots[rank_idx] : '0;
        end
    end

    // Response register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_slot_reg <= rsp_slot_next;
    end

    assign rsp.valid           = rsp_valid_reg;
    assign rsp.ranked_handle   = rsp_slot_reg.handle;
    assign rsp.ranked_present  = rsp_slot_reg.present;
    assign rsp.ranked_distance = rsp_slot_reg.distance;

    // Assertions.
    `NKR_ASSERT_NEXT(a_query_result, is_query, rsp_valid_reg, "Accepted query produced no result.")
    `NKR_ASSERT_NEXT(a_clear_empties, ctrl.clear, $countones(present_vec) == 0, "List not empty after a clear.")
    `NKR_ASSERT_NEXT(a_rank_beyond, is_query && !rank_ok, !rsp_slot_reg.present && (rsp_slot_reg.distance == '0), "Rank beyond the list reported a present slot.")

endmodule

// ===== src/nkr_cell.sv =====
// ----------------------------------------------------------------------------
// nkr_cell
// One slot of the ranking list. The cell compares its stored distance with
// the incoming one, passes a found flag to the next cell and, on an insert,
// either holds, takes the new item or takes its upper neighbor's slot.
// ----------------------------------------------------------------------------
`include "nearest_k_insertion_ranking_macros.svh"

module nkr_cell (
    input  logic               clk,
    input  logic               rst_n,
    input  nkr_pkg::cell_ctrl_t ctrl,
    input  nkr_pkg::slot_t     prev_slot,
    input  logic               prev_found,
    output nkr_pkg::slot_t     slot,
    output logic               found
);
    import nkr_pkg::*;

    slot_t slot_reg;
    slot_t slot_next;
    logic  qualifies;

    // A slot qualifies when its stored distance is zero, as in a free slot, or larger than the incoming one.
    assign qualifies = (slot_reg.distance > ctrl.distance) || (slot_reg.distance == '0);
    assign found     = prev_found || qualifies;
    assign slot      = slot_reg;

    // Next slot contents.
    always_comb
    begin
        slot_next = slot_reg;
        if (ctrl.clear)
        begin
            slot_next = '0;
        end
        else if (ctrl.insert)
        begin
            if (prev_found)
            begin
                slot_next = prev_slot;
            end
            else if (qualifies)
            begin
                slot_next.handle   = ctrl.handle;
                slot_next.present  = 1'b1;
                slot_next.distance = ctrl.distance;
            end
        end
    end

    // Slot register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg <= '0;
        end
        else
        begin
            slot_reg <= slot_next;
        end
    end

    // Assertions.
    `NKR_ASSERT_NEXT(a_cell_shift, ctrl.insert && !ctrl.clear && prev_found, slot_reg == $past(prev_slot), "Cell did not take its neighbor's slot on a shift.")
    `NKR_ASSERT_NEXT(a_cell_write, ctrl.insert && !ctrl.clear && !prev_found && qualifies, slot_reg.present && (slot_reg.distance == $past(ctrl.distance)), "Cell did not store the inserted item.")
    `NKR_ASSERT_NEXT(a_cell_clear, ctrl.clear, !slot_reg.present && (slot_reg.distance == '0), "Cell not empty after a clear.")

endmodule
